[src/fbmcu_pkg.sv]
// fbmcu_pkg: types and action codes shared by the execute unit modules
// depends on nothing

package fbmcu_pkg;

   localparam int ActionWidth = 7;

   typedef enum logic [6:0] {
      ACT_ILL   = 7'd0,  ACT_LAB   = 7'd1,  ACT_LBA   = 7'd2,  ACT_LAY   = 7'd3,
      ACT_LASPX = 7'd4,  ACT_LASPY = 7'd5,  ACT_XAMR  = 7'd6,  ACT_LXA   = 7'd7,
      ACT_LYA   = 7'd8,  ACT_LXI   = 7'd9,  ACT_LYI   = 7'd10, ACT_IY    = 7'd11,
      ACT_DY    = 7'd12, ACT_AYY   = 7'd13, ACT_SYY   = 7'd14, ACT_XSP   = 7'd15,
      ACT_LAM   = 7'd16, ACT_LBM   = 7'd17, ACT_XMA   = 7'd18, ACT_XMB   = 7'd19,
      ACT_LMAIY = 7'd20, ACT_LMADY = 7'd21, ACT_LMIIY = 7'd22, ACT_LAI   = 7'd23,
      ACT_LBI   = 7'd24, ACT_AI    = 7'd25, ACT_IB    = 7'd26, ACT_DB    = 7'd27,
      ACT_AMC   = 7'd28, ACT_SMC   = 7'd29, ACT_AM    = 7'd30, ACT_DAA   = 7'd31,
      ACT_DAS   = 7'd32, ACT_NEGA  = 7'd33, ACT_COMB  = 7'd34, ACT_SEC   = 7'd35,
      ACT_REC   = 7'd36, ACT_TC    = 7'd37, ACT_ROTL  = 7'd38, ACT_ROTR  = 7'd39,
      ACT_OR    = 7'd40, ACT_MNEI  = 7'd41, ACT_YNEI  = 7'd42, ACT_ANEM  = 7'd43,
      ACT_BNEM  = 7'd44, ACT_ALEI  = 7'd45, ACT_ALEM  = 7'd46, ACT_BLEM  = 7'd47,
      ACT_SEM   = 7'd48, ACT_REM   = 7'd49, ACT_TM    = 7'd50, ACT_BR    = 7'd51,
      ACT_CAL   = 7'd52, ACT_TBR   = 7'd53, ACT_RTN   = 7'd54, ACT_SEIE  = 7'd55,
      ACT_SEIF0 = 7'd56, ACT_SEIF1 = 7'd57, ACT_SETF  = 7'd58, ACT_SECF  = 7'd59,
      ACT_REIE  = 7'd60, ACT_REIF0 = 7'd61, ACT_REIF1 = 7'd62, ACT_RETF  = 7'd63,
      ACT_RECF  = 7'd64, ACT_TI0   = 7'd65, ACT_TI1   = 7'd66, ACT_TIF0  = 7'd67,
      ACT_TIF1  = 7'd68, ACT_TTF   = 7'd69, ACT_LTI   = 7'd70, ACT_LTA   = 7'd71,
      ACT_LAT   = 7'd72, ACT_RTNI  = 7'd73, ACT_SED   = 7'd74, ACT_RED   = 7'd75,
      ACT_TD    = 7'd76, ACT_SEDD  = 7'd77, ACT_REDD  = 7'd78, ACT_LAR   = 7'd79,
      ACT_LBR   = 7'd80, ACT_LRA   = 7'd81, ACT_LRB   = 7'd82
   } action_type;

   typedef enum logic [1:0] {
      IO_NONE  = 2'd0,
      IO_LATCH = 2'd1,
      IO_RPORT = 2'd2
   } io_kind_type;

   localparam int CfgFamily  = 0;
   localparam int CfgRamMask = 1;
   localparam int CfgPcMask  = 2;

   // flag bit positions
   localparam int FlagIe  = 0;
   localparam int FlagIf0 = 1;
   localparam int FlagIf1 = 2;
   localparam int FlagTf  = 3;
   localparam int FlagCf  = 4;

   typedef struct packed {
      logic [6:0]  action;
      logic [3:0]  imm_nibble;
      logic [5:0]  op_low_bits;
      logic [11:0] pc_now;
      logic [3:0]  rport_in;
      logic        dpin_in;
      logic        int0_pin;
      logic        int1_pin;
   } req_type;

   typedef struct packed {
      logic [11:0] next_pc;
      logic [3:0]  acc_a;
      logic [3:0]  acc_b;
      logic        status_flag;
      logic        carry_flag;
      logic [1:0]  io_kind;
      logic [3:0]  io_index;
      logic [3:0]  io_value;
      logic        int_enable;
   } rsp_type;

   // write request from the execute stage to the data memory
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [3:0] data;
   } mem_wr_type;

endpackage

[src/fbmcu_ram.sv]
// fbmcu_ram: data memory, one write and one registered read port
// depends on fbmcu_pkg

module fbmcu_ram #(
   parameter int RAM_WORDS = 256
) (
   input  logic                  clock,
   input  logic [7:0]            rd_addr,
   input  fbmcu_pkg::mem_wr_type wr,
   output logic [3:0]            rd_data
);
   localparam int AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

   logic [3:0] mem [RAM_WORDS];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;
endmodule

[src/four_bit_mcu_execute_unit.sv]
// four_bit_mcu_execute_unit: top level of the 4-bit controller execute unit
// depends on fbmcu_pkg and fbmcu_ram
//
// one decoded instruction comes in on the req_ channel, one result item goes
// out on the rsp_ channel for every instruction
// the data memory word an item names is read at the edge that accepts it
// (registered read port, address formed from the pointers the item will
// see); it executes unless the output register stalls it, and the edge
// ending its execution writes the memory back and loads the result into
// the output register, raising rsp_tvalid; throughput is one item every
// cycle while results are taken; the read of a following item is issued
// while the earlier one executes, and a write to the same word by the
// executing item is forwarded into the waiting read data; when the result
// register is full and not taken, the execute stage holds and req_tready
// stays low while that stage holds an item; reset (synchronous, active
// high) clears registers, flags, stack and the configuration to its
// defaults; data memory contents stay undefined; configuration registers
// are written on csr_wen: the user must do so only while idle, unenforced

module four_bit_mcu_execute_unit #(
   parameter int STACK_DEPTH = 4,
   parameter int RAM_WORDS   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action, imm_nibble, op_low_bits, pc_now, rport_in, dpin_in,
   // int0_pin, int1_pin from bit 0 up
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc, acc_a, acc_b, status_flag, carry_flag, io_kind, io_index,
   // io_value, int_enable from bit 0 up
   output logic [39:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   localparam int RamAw = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

   // configuration
   logic        family_ff;
   logic [7:0]  ram_mask_ff;
   logic [11:0] pc_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff   <= 1'b1;
         ram_mask_ff <= 8'hff;
         pc_mask_ff  <= 12'hfff;
      end else if (csr_wen) begin
         case (csr_index)
            2'(fbmcu_pkg::CfgFamily):  family_ff   <= csr_wdata[0];
            2'(fbmcu_pkg::CfgRamMask): ram_mask_ff <= csr_wdata[7:0];
            2'(fbmcu_pkg::CfgPcMask):  pc_mask_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // unpack the input item
   fbmcu_pkg::req_type req;
   assign req.action      = req_tdata[6:0];
   assign req.imm_nibble  = req_tdata[10:7];
   assign req.op_low_bits = req_tdata[16:11];
   assign req.pc_now      = req_tdata[28:17];
   assign req.rport_in    = req_tdata[32:29];
   assign req.dpin_in     = req_tdata[33];
   assign req.int0_pin    = req_tdata[34];
   assign req.int1_pin    = req_tdata[35];

   // architectural state
   logic [3:0] a_ff, b_ff, x_ff, y_ff, sx_ff, sy_ff, tmr_ff;
   logic       c_ff, s_ff;
   logic [4:0] flags_ff;
   logic [11:0] stk_ff [STACK_DEPTH];

   // execute stage holding register
   logic               ex_valid_ff;
   fbmcu_pkg::req_type ex_ff;
   logic [7:0]         ex_addr_ff;

   // output register
   logic                rsp_valid_ff;
   fbmcu_pkg::rsp_type  rsp_ff;

   logic ex_fire, ex_stall, req_fire;
   assign ex_stall   = rsp_valid_ff && !rsp_tready;
   assign ex_fire    = ex_valid_ff && !ex_stall;
   assign req_tready = !ex_valid_ff || !ex_stall;
   assign req_fire   = req_tvalid && req_tready;

   // ---- address of the item in the execute stage as seen by the next one
   // the pointers the next item sees are those after the current execute,
   // so the read address is formed from the next-state pointers
   logic [3:0] x_in, y_in;

   function automatic logic [7:0] mr_addr(input logic fam, input logic [3:0] r);
      logic [7:0] a;
      a = {4'd0, r};
      if (!fam) begin
         a = a | ((r < 4'd4) ? {r, 4'd0} : 8'h40);
      end else begin
         a = a | 8'hf0;
      end
      return a;
   endfunction

   // pointers seen by the incoming item: post-execute if ex fires
   logic [3:0] x_view, y_view;
   assign x_view = ex_fire ? x_in : x_ff;
   assign y_view = ex_fire ? y_in : y_ff;

   logic [7:0] rd_addr;
   always_comb begin
      if (fbmcu_pkg::action_type'(req.action) == fbmcu_pkg::ACT_XAMR) begin
         rd_addr = mr_addr(family_ff, req.op_low_bits[3:0]) & ram_mask_ff;
      end else begin
         rd_addr = {x_view, y_view} & ram_mask_ff;
      end
   end

   // a stalled execute stage keeps its read address; re-read it
   logic [7:0] ram_rd_addr;
   assign ram_rd_addr = req_fire ? rd_addr : ex_addr_ff;

   fbmcu_pkg::mem_wr_type wr;
   logic [3:0] ram_q;

   fbmcu_ram #(.RAM_WORDS(RAM_WORDS)) u_ram (
      .clock   (clock),
      .rd_addr (ram_rd_addr),
      .wr      (wr),
      .rd_data (ram_q)
   );

   // forwarding: a write in the same cycle as the read of the same word
   logic       fwd_ff;
   logic [3:0] fwd_data_ff;
   always_ff @(posedge clock) begin
      fwd_ff      <= wr.en && (wr.addr[RamAw-1:0] == ram_rd_addr[RamAw-1:0]);
      fwd_data_ff <= wr.data;
   end

   logic [3:0] m;
   assign m = fwd_ff ? fwd_data_ff : ram_q;

   // table branch target: A, B, C and op bits 2:0 over the page of pc_now
   logic [11:0] tbr_pc;
   assign tbr_pc = ({ex_ff.pc_now[11:6], 6'd0} |
                    {ex_ff.op_low_bits[2:0], c_ff, b_ff, a_ff}) & pc_mask_ff;

   // ---- execute
   logic [3:0]  a_in, b_in, sx_in, sy_in, tmr_in;
   logic        c_in, s_in;
   logic [4:0]  flags_in;
   logic        push, pop;
   fbmcu_pkg::rsp_type rsp_in;
   logic [4:0]  t5;
   logic [3:0]  bitm;
   logic [11:0] npc, top;
   logic [3:0]  tx, ty;

   always_comb begin
      a_in = a_ff; b_in = b_ff; x_in = x_ff; y_in = y_ff;
      sx_in = sx_ff; sy_in = sy_ff; tmr_in = tmr_ff;
      c_in = c_ff; s_in = s_ff; flags_in = flags_ff;
      push = 1'b0; pop = 1'b0;
      wr.en = 1'b0; wr.addr = ex_addr_ff; wr.data = 4'd0;
      npc = ex_ff.pc_now;
      top = stk_ff[0] & pc_mask_ff;
      bitm = 4'd1 << ex_ff.op_low_bits[1:0];
      t5 = 5'd0;
      rsp_in.io_kind  = fbmcu_pkg::IO_NONE;
      rsp_in.io_index = 4'd0;
      rsp_in.io_value = 4'd0;
      case (fbmcu_pkg::action_type'(ex_ff.action))
         fbmcu_pkg::ACT_LAB:   a_in = b_ff;
         fbmcu_pkg::ACT_LBA:   b_in = a_ff;
         fbmcu_pkg::ACT_LAY:   a_in = y_ff;
         fbmcu_pkg::ACT_LASPX: a_in = sx_ff;
         fbmcu_pkg::ACT_LASPY: a_in = sy_ff;
         fbmcu_pkg::ACT_XAMR: begin
            a_in = m; wr.en = 1'b1; wr.data = a_ff;
         end
         fbmcu_pkg::ACT_LXA: x_in = a_ff;
         fbmcu_pkg::ACT_LYA: y_in = a_ff;
         fbmcu_pkg::ACT_LXI: x_in = ex_ff.imm_nibble;
         fbmcu_pkg::ACT_LYI: y_in = ex_ff.imm_nibble;
         fbmcu_pkg::ACT_IY: begin
            y_in = y_ff + 4'd1; s_in = (y_in != 4'd0);
         end
         fbmcu_pkg::ACT_DY: begin
            y_in = y_ff - 4'd1; s_in = (y_in != 4'hf);
         end
         fbmcu_pkg::ACT_AYY: begin
            t5 = {1'b0, y_ff} + {1'b0, a_ff}; s_in = t5[4]; y_in = t5[3:0];
         end
         fbmcu_pkg::ACT_SYY: begin
            s_in = (y_ff >= a_ff); y_in = y_ff - a_ff;
         end
         fbmcu_pkg::ACT_XSP: ;
         fbmcu_pkg::ACT_LAM: a_in = m;
         fbmcu_pkg::ACT_LBM: b_in = m;
         fbmcu_pkg::ACT_XMA: begin
            a_in = m; wr.en = 1'b1; wr.data = a_ff;
         end
         fbmcu_pkg::ACT_XMB: begin
            b_in = m; wr.en = 1'b1; wr.data = b_ff;
         end
         fbmcu_pkg::ACT_LMAIY: begin
            wr.en = 1'b1; wr.data = a_ff; y_in = y_ff + 4'd1; s_in = (y_in != 4'd0);
         end
         fbmcu_pkg::ACT_LMADY: begin
            wr.en = 1'b1; wr.data = a_ff; y_in = y_ff - 4'd1; s_in = (y_in != 4'hf);
         end
         fbmcu_pkg::ACT_LMIIY: begin
            wr.en = 1'b1; wr.data = ex_ff.imm_nibble;
            y_in = y_ff + 4'd1; s_in = (y_in != 4'd0);
         end
         fbmcu_pkg::ACT_LAI: a_in = ex_ff.imm_nibble;
         fbmcu_pkg::ACT_LBI: b_in = ex_ff.imm_nibble;
         fbmcu_pkg::ACT_AI: begin
            t5 = {1'b0, a_ff} + {1'b0, ex_ff.imm_nibble}; s_in = t5[4]; a_in = t5[3:0];
         end
         fbmcu_pkg::ACT_IB: begin
            b_in = b_ff + 4'd1; s_in = (b_in != 4'd0);
         end
         fbmcu_pkg::ACT_DB: begin
            b_in = b_ff - 4'd1; s_in = (b_in != 4'hf);
         end
         fbmcu_pkg::ACT_AMC: begin
            t5 = {1'b0, a_ff} + {1'b0, m} + {4'd0, c_ff};
            c_in = t5[4]; s_in = t5[4]; a_in = t5[3:0];
         end
         fbmcu_pkg::ACT_SMC: begin
            t5 = {1'b0, m} + 5'd16 - {1'b0, a_ff} - {4'd0, ~c_ff};
            c_in = t5[4]; s_in = t5[4]; a_in = t5[3:0];
         end
         fbmcu_pkg::ACT_AM: begin
            t5 = {1'b0, a_ff} + {1'b0, m}; s_in = t5[4]; a_in = t5[3:0];
         end
         fbmcu_pkg::ACT_DAA: begin
            if (c_ff || a_ff > 4'd9) begin
               a_in = a_ff + 4'd6; c_in = 1'b1;
            end
         end
         fbmcu_pkg::ACT_DAS: begin
            if (!c_ff || a_ff > 4'd9) begin
               a_in = a_ff + 4'd10; c_in = 1'b0;
            end
         end
         fbmcu_pkg::ACT_NEGA: a_in = 4'd0 - a_ff;
         fbmcu_pkg::ACT_COMB: b_in = ~b_ff;
         fbmcu_pkg::ACT_SEC:  c_in = 1'b1;
         fbmcu_pkg::ACT_REC:  c_in = 1'b0;
         fbmcu_pkg::ACT_TC:   s_in = c_ff;
         fbmcu_pkg::ACT_ROTL: begin
            c_in = a_ff[3]; a_in = {a_ff[2:0], c_ff};
         end
         fbmcu_pkg::ACT_ROTR: begin
            c_in = a_ff[0]; a_in = {c_ff, a_ff[3:1]};
         end
         fbmcu_pkg::ACT_OR:   a_in = a_ff | b_ff;
         fbmcu_pkg::ACT_MNEI: s_in = (ex_ff.imm_nibble != m);
         fbmcu_pkg::ACT_YNEI: s_in = (y_ff != ex_ff.imm_nibble);
         fbmcu_pkg::ACT_ANEM: s_in = (a_ff != m);
         fbmcu_pkg::ACT_BNEM: s_in = (b_ff != m);
         fbmcu_pkg::ACT_ALEI: s_in = (a_ff <= ex_ff.imm_nibble);
         fbmcu_pkg::ACT_ALEM: s_in = (a_ff <= m);
         fbmcu_pkg::ACT_BLEM: s_in = (b_ff <= m);
         fbmcu_pkg::ACT_SEM: begin
            wr.en = 1'b1; wr.data = m | bitm;
         end
         fbmcu_pkg::ACT_REM: begin
            wr.en = 1'b1; wr.data = m & ~bitm;
         end
         fbmcu_pkg::ACT_TM: s_in = |(m & bitm);
         fbmcu_pkg::ACT_BR: begin
            if (s_ff) npc = {ex_ff.pc_now[11:6], ex_ff.op_low_bits};
            else s_in = 1'b1;
         end
         fbmcu_pkg::ACT_CAL: begin
            if (s_ff) begin
               push = 1'b1; npc = {6'd0, ex_ff.op_low_bits};
            end else begin
               s_in = 1'b1;
            end
         end
         fbmcu_pkg::ACT_TBR: npc = tbr_pc;
         fbmcu_pkg::ACT_RTN: begin
            pop = 1'b1; npc = top;
         end
         fbmcu_pkg::ACT_SEIE:  flags_in[fbmcu_pkg::FlagIe]  = 1'b1;
         fbmcu_pkg::ACT_SEIF0: flags_in[fbmcu_pkg::FlagIf0] = 1'b1;
         fbmcu_pkg::ACT_SEIF1: flags_in[fbmcu_pkg::FlagIf1] = 1'b1;
         fbmcu_pkg::ACT_SETF:  flags_in[fbmcu_pkg::FlagTf]  = 1'b1;
         fbmcu_pkg::ACT_SECF:  flags_in[fbmcu_pkg::FlagCf]  = 1'b1;
         fbmcu_pkg::ACT_REIE:  flags_in[fbmcu_pkg::FlagIe]  = 1'b0;
         fbmcu_pkg::ACT_REIF0: flags_in[fbmcu_pkg::FlagIf0] = 1'b0;
         fbmcu_pkg::ACT_REIF1: flags_in[fbmcu_pkg::FlagIf1] = 1'b0;
         fbmcu_pkg::ACT_RETF:  flags_in[fbmcu_pkg::FlagTf]  = 1'b0;
         fbmcu_pkg::ACT_RECF:  flags_in[fbmcu_pkg::FlagCf]  = 1'b0;
         fbmcu_pkg::ACT_TI0:   s_in = ex_ff.int0_pin;
         fbmcu_pkg::ACT_TI1:   s_in = ex_ff.int1_pin;
         fbmcu_pkg::ACT_TIF0:  s_in = flags_ff[fbmcu_pkg::FlagIf0];
         fbmcu_pkg::ACT_TIF1:  s_in = flags_ff[fbmcu_pkg::FlagIf1];
         fbmcu_pkg::ACT_TTF:   s_in = flags_ff[fbmcu_pkg::FlagTf];
         fbmcu_pkg::ACT_LTI:   tmr_in = ex_ff.imm_nibble;
         fbmcu_pkg::ACT_LTA:   tmr_in = a_ff;
         fbmcu_pkg::ACT_LAT:   a_in = tmr_ff;
         fbmcu_pkg::ACT_RTNI: begin
            flags_in[fbmcu_pkg::FlagIe] = 1'b1; pop = 1'b1; npc = top;
         end
         fbmcu_pkg::ACT_SED: begin
            rsp_in.io_kind = fbmcu_pkg::IO_LATCH; rsp_in.io_index = y_ff;
            rsp_in.io_value = 4'd1;
         end
         fbmcu_pkg::ACT_RED: begin
            rsp_in.io_kind = fbmcu_pkg::IO_LATCH; rsp_in.io_index = y_ff;
         end
         fbmcu_pkg::ACT_TD: s_in = ex_ff.dpin_in;
         fbmcu_pkg::ACT_SEDD: begin
            rsp_in.io_kind = fbmcu_pkg::IO_LATCH;
            rsp_in.io_index = {2'd0, ex_ff.op_low_bits[1:0]}; rsp_in.io_value = 4'd1;
         end
         fbmcu_pkg::ACT_REDD: begin
            rsp_in.io_kind = fbmcu_pkg::IO_LATCH;
            rsp_in.io_index = {2'd0, ex_ff.op_low_bits[1:0]};
         end
         fbmcu_pkg::ACT_LAR: a_in = ex_ff.rport_in;
         fbmcu_pkg::ACT_LBR: b_in = ex_ff.rport_in;
         fbmcu_pkg::ACT_LRA: begin
            rsp_in.io_kind = fbmcu_pkg::IO_RPORT;
            rsp_in.io_index = {1'b0, ex_ff.op_low_bits[2:0]}; rsp_in.io_value = a_ff;
         end
         fbmcu_pkg::ACT_LRB: begin
            rsp_in.io_kind = fbmcu_pkg::IO_RPORT;
            rsp_in.io_index = {1'b0, ex_ff.op_low_bits[2:0]}; rsp_in.io_value = b_ff;
         end
         default: ;
      endcase
      // pointer exchange after the memory access
      case (fbmcu_pkg::action_type'(ex_ff.action))
         fbmcu_pkg::ACT_XSP, fbmcu_pkg::ACT_LAM, fbmcu_pkg::ACT_LBM,
         fbmcu_pkg::ACT_XMA, fbmcu_pkg::ACT_XMB, fbmcu_pkg::ACT_LMAIY,
         fbmcu_pkg::ACT_LMADY: begin
            tx = x_in; ty = y_in;
            if (ex_ff.op_low_bits[0]) begin
               x_in = sx_ff; sx_in = tx;
            end
            if (ex_ff.op_low_bits[1]) begin
               y_in = sy_ff; sy_in = ty;
            end
         end
         default: begin
            tx = 4'd0; ty = 4'd0;
         end
      endcase
      wr.en = wr.en && ex_fire;
      rsp_in.next_pc     = npc;
      rsp_in.acc_a       = a_in;
      rsp_in.acc_b       = b_in;
      rsp_in.status_flag = s_in;
      rsp_in.carry_flag  = c_in;
      rsp_in.int_enable  = flags_in[fbmcu_pkg::FlagIe];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; x_ff <= '0; y_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; tmr_ff <= '0;
         c_ff <= 1'b0; s_ff <= 1'b1; flags_ff <= '0;
         for (int k = 0; k < STACK_DEPTH; k++) stk_ff[k] <= '0;
         ex_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ex_fire) begin
            a_ff <= a_in; b_ff <= b_in; x_ff <= x_in; y_ff <= y_in;
            sx_ff <= sx_in; sy_ff <= sy_in; tmr_ff <= tmr_in;
            c_ff <= c_in; s_ff <= s_in; flags_ff <= flags_in;
            if (push) begin
               for (int k = STACK_DEPTH - 1; k >= 1; k--) stk_ff[k] <= stk_ff[k-1];
               stk_ff[0] <= ex_ff.pc_now;
            end else if (pop) begin
               for (int k = 0; k < STACK_DEPTH - 1; k++) stk_ff[k] <= stk_ff[k+1];
            end
         end
         if (req_fire) ex_valid_ff <= 1'b1;
         else if (ex_fire) ex_valid_ff <= 1'b0;
         if (ex_fire) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ex_ff      <= req;
         ex_addr_ff <= rd_addr;
      end
      if (ex_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.int_enable, rsp_ff.io_value, rsp_ff.io_index,
                        rsp_ff.io_kind, rsp_ff.carry_flag, rsp_ff.status_flag,
                        rsp_ff.acc_b, rsp_ff.acc_a, rsp_ff.next_pc};

   // checks
   a_no_fire_without_item: assert property (@(posedge clock) disable iff (reset)
      ex_fire |-> ex_valid_ff) else $error("execute without item");
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      ex_fire |=> rsp_tvalid) else $error("result lost");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("result changed");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> ex_fire) else $error("stray memory write");
endmodule

[test/tb.sv]
// tb: self-checking bench for four_bit_mcu_execute_unit
// depends on fbmcu_pkg and the execute unit
// drives decoded instructions in, checks every result item

module tb;

   // behaviour of the execute unit plus the store of results still owed
   class exec_scoreboard;
      bit        family;
      bit [7:0]  ram_mask;
      bit [11:0] pc_mask;
      bit [3:0]  a, b, x, y, spx, spy, tval;
      bit        c, s;
      bit [4:0]  flags;
      bit [3:0]  ram [256];
      bit        written [256];
      bit [11:0] stack [4];
      bit [39:0] owed [$];
      int        mismatches;

      function void clear();
         family = 1; ram_mask = 8'hff; pc_mask = 12'hfff;
         {a, b, x, y, spx, spy, tval} = '0;
         c = 0; s = 1; flags = '0;
         foreach (stack[k]) stack[k] = '0;
         foreach (written[k]) written[k] = 0;
         owed.delete();
      endfunction

      function bit [7:0] xy_cell();
         return {x, y} & ram_mask;
      endfunction

      function bit [7:0] mr_cell(bit [5:0] op);
         bit [7:0] addr;
         addr = {4'h0, op[3:0]};
         if (!family) addr = addr | ((op[3:0] < 4'd4) ? {op[3:0], 4'h0} : 8'h40);
         else addr = addr | 8'hf0;
         return addr & ram_mask;
      endfunction

      function void mem_put(bit [3:0] v);
         ram[xy_cell()] = v;
         written[xy_cell()] = 1;
      endfunction

      function void swap_ptrs(bit [5:0] sel);
         bit [3:0] t;
         if (sel[0]) begin t = x; x = spx; spx = t; end
         if (sel[1]) begin t = y; y = spy; spy = t; end
      endfunction

      function bit [11:0] pop_return();
         bit [11:0] top;
         top = stack[0] & pc_mask;
         for (int k = 0; k < 3; k++) stack[k] = stack[k + 1];
         return top;
      endfunction

      // true when the item would read a memory word never written
      function bit touches_unwritten(bit [39:0] item);
         bit [6:0] act;
         act = item[6:0];
         if (act == fbmcu_pkg::ACT_XAMR) return !written[mr_cell(item[16:11])];
         case (act)
            fbmcu_pkg::ACT_LAM, fbmcu_pkg::ACT_LBM, fbmcu_pkg::ACT_XMA,
            fbmcu_pkg::ACT_XMB, fbmcu_pkg::ACT_AMC, fbmcu_pkg::ACT_SMC,
            fbmcu_pkg::ACT_AM, fbmcu_pkg::ACT_MNEI, fbmcu_pkg::ACT_ANEM,
            fbmcu_pkg::ACT_BNEM, fbmcu_pkg::ACT_ALEM, fbmcu_pkg::ACT_BLEM,
            fbmcu_pkg::ACT_SEM, fbmcu_pkg::ACT_REM, fbmcu_pkg::ACT_TM:
               return !written[xy_cell()];
            default: return 0;
         endcase
      endfunction

      function void note_instruction(bit [39:0] item);
         bit [6:0]  act;
         bit [3:0]  imm, rin, m, idx, val, t4;
         bit [5:0]  op;
         bit [11:0] pc, npc;
         bit [1:0]  kind;
         bit        din, i0, i1;
         bit [7:0]  addr;
         int        t;
         act = item[6:0]; imm = item[10:7]; op = item[16:11]; pc = item[28:17];
         rin = item[32:29]; din = item[33]; i0 = item[34]; i1 = item[35];
         npc = pc; kind = fbmcu_pkg::IO_NONE; idx = 0; val = 0;
         m = written[xy_cell()] ? ram[xy_cell()] : 4'h0;
         case (act)
            fbmcu_pkg::ACT_LAB:   a = b;
            fbmcu_pkg::ACT_LBA:   b = a;
            fbmcu_pkg::ACT_LAY:   a = y;
            fbmcu_pkg::ACT_LASPX: a = spx;
            fbmcu_pkg::ACT_LASPY: a = spy;
            fbmcu_pkg::ACT_XAMR: begin
               addr = mr_cell(op);
               t4 = a; a = ram[addr]; ram[addr] = t4; written[addr] = 1;
            end
            fbmcu_pkg::ACT_LXA:   x = a;
            fbmcu_pkg::ACT_LYA:   y = a;
            fbmcu_pkg::ACT_LXI:   x = imm;
            fbmcu_pkg::ACT_LYI:   y = imm;
            fbmcu_pkg::ACT_IY:    begin y = y + 1; s = (y != 0); end
            fbmcu_pkg::ACT_DY:    begin y = y - 1; s = (y != 4'hf); end
            fbmcu_pkg::ACT_AYY:   begin t = y + a; s = t[4]; y = t[3:0]; end
            fbmcu_pkg::ACT_SYY:   begin s = (y >= a); y = y - a; end
            fbmcu_pkg::ACT_XSP:   swap_ptrs(op);
            fbmcu_pkg::ACT_LAM:   begin a = m; swap_ptrs(op); end
            fbmcu_pkg::ACT_LBM:   begin b = m; swap_ptrs(op); end
            fbmcu_pkg::ACT_XMA:   begin mem_put(a); a = m; swap_ptrs(op); end
            fbmcu_pkg::ACT_XMB:   begin mem_put(b); b = m; swap_ptrs(op); end
            fbmcu_pkg::ACT_LMAIY:
               begin mem_put(a); y = y + 1; s = (y != 0); swap_ptrs(op); end
            fbmcu_pkg::ACT_LMADY:
               begin mem_put(a); y = y - 1; s = (y != 4'hf); swap_ptrs(op); end
            fbmcu_pkg::ACT_LMIIY: begin mem_put(imm); y = y + 1; s = (y != 0); end
            fbmcu_pkg::ACT_LAI:   a = imm;
            fbmcu_pkg::ACT_LBI:   b = imm;
            fbmcu_pkg::ACT_AI:    begin t = a + imm; s = t[4]; a = t[3:0]; end
            fbmcu_pkg::ACT_IB:    begin b = b + 1; s = (b != 0); end
            fbmcu_pkg::ACT_DB:    begin b = b - 1; s = (b != 4'hf); end
            fbmcu_pkg::ACT_AMC:   begin t = a + m + c; c = t[4]; s = c; a = t[3:0]; end
            fbmcu_pkg::ACT_SMC:
               begin t = m + 16 - a - (c ^ 1); c = t[4]; s = c; a = t[3:0]; end
            fbmcu_pkg::ACT_AM:    begin t = a + m; s = t[4]; a = t[3:0]; end
            fbmcu_pkg::ACT_DAA:   if (c || a > 9) begin a = a + 6; c = 1; end
            fbmcu_pkg::ACT_DAS:   if (!c || a > 9) begin a = a + 10; c = 0; end
            fbmcu_pkg::ACT_NEGA:  a = -a;
            fbmcu_pkg::ACT_COMB:  b = ~b;
            fbmcu_pkg::ACT_SEC:   c = 1;
            fbmcu_pkg::ACT_REC:   c = 0;
            fbmcu_pkg::ACT_TC:    s = c;
            fbmcu_pkg::ACT_ROTL:  begin t4 = a; a = {t4[2:0], c}; c = t4[3]; end
            fbmcu_pkg::ACT_ROTR:  begin t4 = a; a = {c, t4[3:1]}; c = t4[0]; end
            fbmcu_pkg::ACT_OR:    a = a | b;
            fbmcu_pkg::ACT_MNEI:  s = (imm != m);
            fbmcu_pkg::ACT_YNEI:  s = (y != imm);
            fbmcu_pkg::ACT_ANEM:  s = (a != m);
            fbmcu_pkg::ACT_BNEM:  s = (b != m);
            fbmcu_pkg::ACT_ALEI:  s = (a <= imm);
            fbmcu_pkg::ACT_ALEM:  s = (a <= m);
            fbmcu_pkg::ACT_BLEM:  s = (b <= m);
            fbmcu_pkg::ACT_SEM:   mem_put(m | (4'h1 << op[1:0]));
            fbmcu_pkg::ACT_REM:   mem_put(m & ~(4'h1 << op[1:0]));
            fbmcu_pkg::ACT_TM:    s = m[op[1:0]];
            fbmcu_pkg::ACT_BR:
               if (s) npc = (pc & 12'hfc0) | {6'h0, op}; else s = 1;
            fbmcu_pkg::ACT_CAL:
               if (s) begin
                  for (int k = 3; k >= 1; k--) stack[k] = stack[k - 1];
                  stack[0] = pc;
                  npc = {6'h0, op};
               end else s = 1;
            fbmcu_pkg::ACT_TBR:
               npc = ({8'h0, a} | {4'h0, b, 4'h0} | {3'h0, c, 8'h0} | {op[2:0], 9'h0}
                      | (pc & 12'hfc0)) & pc_mask;
            fbmcu_pkg::ACT_RTN:   npc = pop_return();
            fbmcu_pkg::ACT_SEIE:  flags[fbmcu_pkg::FlagIe] = 1;
            fbmcu_pkg::ACT_SEIF0: flags[fbmcu_pkg::FlagIf0] = 1;
            fbmcu_pkg::ACT_SEIF1: flags[fbmcu_pkg::FlagIf1] = 1;
            fbmcu_pkg::ACT_SETF:  flags[fbmcu_pkg::FlagTf] = 1;
            fbmcu_pkg::ACT_SECF:  flags[fbmcu_pkg::FlagCf] = 1;
            fbmcu_pkg::ACT_REIE:  flags[fbmcu_pkg::FlagIe] = 0;
            fbmcu_pkg::ACT_REIF0: flags[fbmcu_pkg::FlagIf0] = 0;
            fbmcu_pkg::ACT_REIF1: flags[fbmcu_pkg::FlagIf1] = 0;
            fbmcu_pkg::ACT_RETF:  flags[fbmcu_pkg::FlagTf] = 0;
            fbmcu_pkg::ACT_RECF:  flags[fbmcu_pkg::FlagCf] = 0;
            fbmcu_pkg::ACT_TI0:   s = i0;
            fbmcu_pkg::ACT_TI1:   s = i1;
            fbmcu_pkg::ACT_TIF0:  s = flags[fbmcu_pkg::FlagIf0];
            fbmcu_pkg::ACT_TIF1:  s = flags[fbmcu_pkg::FlagIf1];
            fbmcu_pkg::ACT_TTF:   s = flags[fbmcu_pkg::FlagTf];
            fbmcu_pkg::ACT_LTI:   tval = imm;
            fbmcu_pkg::ACT_LTA:   tval = a;
            fbmcu_pkg::ACT_LAT:   a = tval;
            fbmcu_pkg::ACT_RTNI:
               begin flags[fbmcu_pkg::FlagIe] = 1; npc = pop_return(); end
            fbmcu_pkg::ACT_SED:
               begin kind = fbmcu_pkg::IO_LATCH; idx = y; val = 1; end
            fbmcu_pkg::ACT_RED:
               begin kind = fbmcu_pkg::IO_LATCH; idx = y; val = 0; end
            fbmcu_pkg::ACT_TD:    s = din;
            fbmcu_pkg::ACT_SEDD:
               begin kind = fbmcu_pkg::IO_LATCH; idx = {2'b00, op[1:0]}; val = 1; end
            fbmcu_pkg::ACT_REDD:
               begin kind = fbmcu_pkg::IO_LATCH; idx = {2'b00, op[1:0]}; val = 0; end
            fbmcu_pkg::ACT_LAR:   a = rin;
            fbmcu_pkg::ACT_LBR:   b = rin;
            fbmcu_pkg::ACT_LRA:
               begin kind = fbmcu_pkg::IO_RPORT; idx = {1'b0, op[2:0]}; val = a; end
            fbmcu_pkg::ACT_LRB:
               begin kind = fbmcu_pkg::IO_RPORT; idx = {1'b0, op[2:0]}; val = b; end
            default: ;
         endcase
         owed.push_back({7'h0, flags[fbmcu_pkg::FlagIe], val, idx, kind, c, s, b, a, npc});
      endfunction

      function void check_result(bit [39:0] got);
         bit [39:0] want;
         int lo [9] = '{0, 12, 16, 20, 21, 22, 24, 28, 32};
         int wd [9] = '{12, 4, 4, 1, 1, 2, 4, 4, 1};
         string nm [9] = '{"next_pc", "acc_a", "acc_b", "status_flag", "carry_flag",
                           "io_kind", "io_index", "io_value", "int_enable"};
         bit [11:0] mask;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", got);
            return;
         end
         want = owed.pop_front();
         for (int f = 0; f < 9; f++) begin
            mask = 12'((13'h1 << wd[f]) - 13'h1);
            if (((got >> lo[f]) & mask) != ((want >> lo[f]) & mask)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%s: expected %h, got %h", nm[f],
                           (want >> lo[f]) & mask, (got >> lo[f]) & mask);
            end
         end
      endfunction
   endclass

   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   exec_scoreboard sb = new();
   int  tx_idle, rx_idle;
   int  cycles;

   four_bit_mcu_execute_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // runaway guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   // result side: check on handshake, then decide whether to stall next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= !reset && ($urandom_range(99) >= rx_idle);
   end

   function automatic bit [39:0] pack_item(bit [6:0] act, bit [3:0] imm, bit [5:0] op,
                                           bit [11:0] pc, bit [3:0] rin, bit din,
                                           bit i0, bit i1);
      return {4'h0, i1, i0, din, rin, pc, op, imm, act};
   endfunction

   // one instruction on the request side; a read of an unwritten word becomes
   // a store with auto-increment so the memory fills up as the run goes on
   task automatic send_instruction(bit [39:0] item);
      if (sb.touches_unwritten(item)) item[6:0] = fbmcu_pkg::ACT_LMIIY;
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      sb.note_instruction(item);
   endtask

   task automatic random_instruction();
      bit [6:0] act;
      if ($urandom_range(99) < 8)
         act = ($urandom_range(1) != 0) ? 7'd0 : 7'($urandom_range(83, 127));
      else if ($urandom_range(99) < 10) act = fbmcu_pkg::ACT_LMIIY;
      else act = 7'($urandom_range(1, 82));
      send_instruction(pack_item(act, 4'($urandom_range(15)), 6'($urandom_range(63)),
                                 12'($urandom_range(4095)), 4'($urandom_range(15)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 1'($urandom_range(1))));
   endtask

   // let the pipe drain so registers change only while idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_config(bit fam, bit [7:0] rmask, bit [11:0] pmask);
      csr_wen <= 1'b1; csr_index <= 2'(fbmcu_pkg::CfgFamily); csr_wdata <= {11'h0, fam};
      @(posedge clock);
      csr_index <= 2'(fbmcu_pkg::CfgRamMask); csr_wdata <= {4'h0, rmask};
      @(posedge clock);
      csr_index <= 2'(fbmcu_pkg::CfgPcMask); csr_wdata <= pmask;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      sb.family = fam; sb.ram_mask = rmask; sb.pc_mask = pmask;
   endtask

   initial begin
      bit [11:0] cfg_pc [6]  = '{12'hfff, 12'h0ff, 12'h000, 12'hfff, 12'h555, 12'hfc3};
      bit [7:0]  cfg_ram [6] = '{8'hff, 8'h0f, 8'h00, 8'hff, 8'haa, 8'h3c};
      sb.clear();
      tx_idle = 38; rx_idle = 88;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: extremes, wrap of Y, untaken branch, taken branch and call,
      // returns, table branch, port writes, pins and unused actions
      send_instruction(pack_item(fbmcu_pkg::ACT_LXI, 4'hf, 6'h00, 12'h000, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_LYI, 4'hf, 6'h3f, 12'hfff, 4'hf,
                                 1'b1, 1'b1, 1'b1));
      send_instruction(pack_item(fbmcu_pkg::ACT_LMIIY, 4'hf, 6'h00, 12'h001, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_BR, 4'h0, 6'h3f, 12'hfff, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_CAL, 4'h0, 6'h3f, 12'hfff, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_BR, 4'h0, 6'h3f, 12'h7c1, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_CAL, 4'h0, 6'h2a, 12'hfff, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_XAMR, 4'h0, 6'h3f, 12'h010, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_LAR, 4'h0, 6'h00, 12'h020, 4'hf,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_LBR, 4'h0, 6'h00, 12'h021, 4'hf,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_SEC, 4'h0, 6'h00, 12'h022, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_TBR, 4'h0, 6'h3f, 12'hfc0, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_RTN, 4'h0, 6'h00, 12'h030, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_RTNI, 4'h0, 6'h00, 12'h031, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_LRA, 4'h0, 6'h3f, 12'h032, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_LRB, 4'h0, 6'h07, 12'h033, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_SEDD, 4'h0, 6'h3f, 12'h034, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_SED, 4'h0, 6'h00, 12'h035, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_TD, 4'h0, 6'h00, 12'h036, 4'h0,
                                 1'b1, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_TI1, 4'h0, 6'h00, 12'h037, 4'h0,
                                 1'b0, 1'b0, 1'b1));
      send_instruction(pack_item(fbmcu_pkg::ACT_DAA, 4'h0, 6'h00, 12'h038, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(fbmcu_pkg::ACT_DAS, 4'h0, 6'h00, 12'h039, 4'h0,
                                 1'b0, 1'b0, 1'b0));
      send_instruction(pack_item(7'd127, 4'hf, 6'h3f, 12'hfff, 4'hf, 1'b1, 1'b1, 1'b1));
      send_instruction(pack_item(fbmcu_pkg::ACT_ILL, 4'hf, 6'h3f, 12'hfff, 4'hf,
                                 1'b1, 1'b1, 1'b1));

      // six phases, each with its own register setting; idling pattern
      // changes every two phases
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         set_config(ph[0], cfg_ram[ph], cfg_pc[ph]);
         if (ph < 2) begin tx_idle = 38; rx_idle = 88; end
         else if (ph < 4) begin tx_idle = 88; rx_idle = 38; end
         else begin tx_idle = 0; rx_idle = 0; end
         repeat (288) random_instruction();
      end

      drain();
      if (sb.mismatches == 0 && sb.owed.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

[four_bit_mcu_execute_unit.f]
src/fbmcu_pkg.sv
src/fbmcu_ram.sv
src/four_bit_mcu_execute_unit.sv
test/tb.sv
